// ----- hw/rtl/tcsw_pkg.sv -----
// Shared types, constants and helpers for the scrollback console writer.
package tcsw_pkg;

    // Geometry of the character ring
    localparam int LINES   = 256;
    localparam int COLUMNS = 80;
    localparam int CELLS   = LINES * COLUMNS;

    localparam int LINE_W = $clog2(LINES);
    localparam int CELL_W = $clog2(CELLS);
    localparam int HI_W   = $clog2(COLUMNS + 1);
    localparam int COL_W  = 7;
    localparam int CMP_W  = 8;
    localparam int INFO_W = HI_W + 16;
    localparam int CELL_DATA_W = 24;

    // Operation codes
    localparam logic [2:0] FUNC_PUT_CHAR  = 3'd0;
    localparam logic [2:0] FUNC_SET_COLOR = 3'd1;
    localparam logic [2:0] FUNC_TICK      = 3'd2;
    localparam logic [2:0] FUNC_SCROLL    = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;
    localparam logic [2:0] FUNC_READ_CELL = 3'd5;

    // Register indexes
    localparam logic [1:0] CFG_ENABLE      = 2'd0;
    localparam logic [1:0] CFG_DIVIDER     = 2'd1;
    localparam logic [1:0] CFG_CLEAR_COLOR = 2'd2;

    // Bytes with a meaning of their own
    localparam logic [7:0] KEY_ESC         = 8'h1B;
    localparam logic [7:0] KEY_LF          = 8'h0A;
    localparam logic [7:0] KEY_CR          = 8'h0D;
    localparam logic [7:0] KEY_BS          = 8'h08;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    // Reset values
    localparam logic [7:0]  DIVIDER_RESET     = 8'd50;
    localparam logic [15:0] CLEAR_COLOR_RESET = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         char_code;
        logic [15:0]        new_color;
        logic signed [15:0] scroll_lines;
        logic [7:0]         read_row;
        logic [6:0]         read_column;
    } tcsw_in_t;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [31:0] head_count;
        logic [31:0] scrollback_offset;
        logic        cursor_shown;
        logic        escape_active;
        logic [7:0]  cell_char;
        logic [15:0] cell_color;
    } tcsw_out_t;

    // Read request into the store
    typedef struct packed {
        logic              en;
        logic [LINE_W-1:0] row;
        logic [COL_W-1:0]  col;
    } store_rd_t;

    // Write request into the store
    typedef struct packed {
        logic              cell_we;
        logic [LINE_W-1:0] cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [7:0]        cell_char;
        logic [15:0]       cell_color;
        logic              info_we;
        logic [LINE_W-1:0] info_row;
        logic [HI_W-1:0]   info_hi;
        logic [15:0]       info_fill;
        logic              clear_all;
    } store_wr_t;

    // Live line status kept in registers by the control
    typedef struct packed {
        logic [LINE_W-1:0] row;
        logic [HI_W-1:0]   hi;
        logic [15:0]       fill;
        logic [15:0]       base_color;
    } store_head_t;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [15:0] cell_color;
    } store_rsp_t;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [LINE_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [CELL_W:0] prod;
        prod = (CELL_W + 1)'(row) * (CELL_W + 1)'(COLUMNS) + (CELL_W + 1)'(col);
        return prod[CELL_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/tcsw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module tcsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tcsw_store.sv -----
// Cell memory, per-line fill markers and cell read resolution.
module tcsw_store import tcsw_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  store_rd_t   rd,
    input  store_wr_t   wr,
    input  store_head_t head,
    output store_rsp_t  rsp
);

    logic [CELL_DATA_W-1:0] cell_rdata;
    logic [INFO_W-1:0]      info_rdata;
    logic [LINES-1:0]       line_valid_reg;
    logic [LINE_W-1:0]      row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [HI_W-1:0]        line_hi;
    logic [15:0]            line_fill;
    logic                   hit;

    tcsw_ram #(.WIDTH(CELL_DATA_W), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (wr.cell_we),
        .waddr (cell_addr(wr.cell_row, wr.cell_col)),
        .wdata ({wr.cell_char, wr.cell_color}),
        .re    (rd.en),
        .raddr (cell_addr(rd.row, rd.col)),
        .rdata (cell_rdata)
    );

    // Per line: how many leading cells were written since the wipe, and its fill color
    tcsw_ram #(.WIDTH(INFO_W), .DEPTH(LINES)) u_info_ram (
        .clk   (clk),
        .we    (wr.info_we),
        .waddr (wr.info_row),
        .wdata ({wr.info_hi, wr.info_fill}),
        .re    (rd.en),
        .raddr (rd.row),
        .rdata (info_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
        end
        else if (wr.clear_all)
        begin
            line_valid_reg <= '0;
        end
        else if (wr.info_we)
        begin
            line_valid_reg[wr.info_row] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            row_reg <= rd.row;
            col_reg <= rd.col;
        end
    end

    // Live line comes from registers, finished lines from the info RAM,
    // untouched lines read as blank in the base color.
    always_comb
    begin
        if (row_reg == head.row)
        begin
            line_hi   = head.hi;
            line_fill = head.fill;
        end
        else if (line_valid_reg[row_reg])
        begin
            line_hi   = info_rdata[INFO_W-1:16];
            line_fill = info_rdata[15:0];
        end
        else
        begin
            line_hi   = '0;
            line_fill = head.base_color;
        end
        hit = CMP_W'(col_reg) < CMP_W'(line_hi);
        rsp.cell_char  = hit ? cell_rdata[CELL_DATA_W-1:16] : 8'd0;
        rsp.cell_color = hit ? cell_rdata[15:0] : line_fill;
    end

endmodule

// ----- hw/rtl/text_console_scrollback_writer.sv -----
// Text console writer: each request passes an accept state, then an execute state, which
// waits while the previous result is still unread (out_valid set, out_ready low). The
// accept cycle issues reads of the cell RAM and the line-info RAM; the execute cycle sees
// the registered read data, updates the console registers, writes back at most one cell
// and one line marker, and loads the result register. A new request is taken in the cycle
// after a result is loaded, even while that result still waits for out_ready. Newline, wrap and
// clear do not walk cells: every ring line carries a marker (valid bit plus written-prefix
// length and fill color), so cells past the prefix read as blank in the line's fill color
// and no clearing pass follows reset. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while the console is idle.
module text_console_scrollback_writer import tcsw_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tcsw_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tcsw_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    localparam int RX_W = LINE_W + 8;

    state_t            state_reg, state_next;
    tcsw_in_t          req_reg, req_next;
    logic              out_valid_reg, out_valid_next;
    tcsw_out_t         out_data_reg, out_data_next;

    // configuration
    logic              enable_reg, enable_next;
    logic [7:0]        divider_reg, divider_next;
    logic [15:0]       clear_color_reg, clear_color_next;

    // console state
    logic [COL_W-1:0]  cursor_reg, cursor_next;
    logic [31:0]       head_lines_reg, head_lines_next;
    logic [LINE_W-1:0] head_row_reg, head_row_next;
    logic [HI_W-1:0]   head_hi_reg, head_hi_next;
    logic [15:0]       head_fill_reg, head_fill_next;
    logic [15:0]       base_color_reg, base_color_next;
    logic [31:0]       view_back_reg, view_back_next;
    logic [15:0]       text_color_reg, text_color_next;
    logic              escape_reg, escape_next;
    logic [7:0]        blink_count_reg, blink_count_next;
    logic              blink_phase_reg, blink_phase_next;

    store_rd_t         store_rd;
    store_wr_t         store_wr;
    store_head_t       store_head;
    store_rsp_t        store_rsp;
    logic [RX_W-1:0]   row_ext;
    logic              fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign fire      = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // Reads go out in the accept cycle: the addressed cell for a cell read,
    // otherwise the cell left of the cursor for a possible backspace.
    assign row_ext = RX_W'(in_data.read_row);
    always_comb
    begin
        store_rd.en = in_valid && in_ready;
        if (in_data.func == FUNC_READ_CELL)
        begin
            store_rd.row = row_ext[LINE_W-1:0];
            store_rd.col = in_data.read_column;
        end
        else
        begin
            store_rd.row = head_row_reg;
            store_rd.col = cursor_reg - COL_W'(1);
        end
    end

    assign store_head = '{row: head_row_reg, hi: head_hi_reg, fill: head_fill_reg,
                          base_color: base_color_reg};

    tcsw_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (store_rd),
        .wr    (store_wr),
        .head  (store_head),
        .rsp   (store_rsp)
    );

    always_comb
    begin
        logic [7:0]        c;
        logic [CMP_W-1:0]  c1;
        logic              advance;
        logic [HI_W-1:0]   fin_hi;
        logic signed [33:0] v;
        logic [7:0]        cnt;
        logic              in_range;

        state_next       = state_reg;
        req_next         = req_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        enable_next      = enable_reg;
        divider_next     = divider_reg;
        clear_color_next = clear_color_reg;
        cursor_next      = cursor_reg;
        head_lines_next  = head_lines_reg;
        head_row_next    = head_row_reg;
        head_hi_next     = head_hi_reg;
        head_fill_next   = head_fill_reg;
        base_color_next  = base_color_reg;
        view_back_next   = view_back_reg;
        text_color_next  = text_color_reg;
        escape_next      = escape_reg;
        blink_count_next = blink_count_reg;
        blink_phase_next = blink_phase_reg;
        store_wr         = '0;
        c                = req_reg.char_code;
        c1               = CMP_W'(cursor_reg) + CMP_W'(1);
        advance          = 1'b0;
        fin_hi           = head_hi_reg;
        v                = '0;
        cnt              = blink_count_reg + 8'd1;
        in_range         = (int'(req_reg.read_row) < LINES)
                           && (int'(req_reg.read_column) < COLUMNS);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENABLE:      enable_next      = cfg_data[0];
                CFG_DIVIDER:     divider_next     = cfg_data[7:0];
                CFG_CLEAR_COLOR: clear_color_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    case (req_reg.func)
                        FUNC_PUT_CHAR:
                        begin
                            if (escape_reg)
                            begin
                                if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                                    || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z))
                                begin
                                    escape_next = 1'b0;
                                end
                            end
                            else if (c == KEY_ESC)
                            begin
                                escape_next = 1'b1;
                            end
                            else
                            begin
                                view_back_next = '0;
                                if (enable_reg)
                                begin
                                    if (c == KEY_LF)
                                    begin
                                        advance = 1'b1;
                                    end
                                    else if (c == KEY_CR)
                                    begin
                                        cursor_next = '0;
                                    end
                                    else if (c == KEY_BS)
                                    begin
                                        // cell left of cursor lies in the written prefix
                                        if (cursor_reg != '0)
                                        begin
                                            cursor_next         = cursor_reg - COL_W'(1);
                                            store_wr.cell_we    = 1'b1;
                                            store_wr.cell_row   = head_row_reg;
                                            store_wr.cell_col   = cursor_reg - COL_W'(1);
                                            store_wr.cell_char  = 8'd0;
                                            store_wr.cell_color = store_rsp.cell_color;
                                        end
                                    end
                                    else if (c >= FIRST_PRINTABLE)
                                    begin
                                        store_wr.cell_we    = 1'b1;
                                        store_wr.cell_row   = head_row_reg;
                                        store_wr.cell_col   = cursor_reg;
                                        store_wr.cell_char  = c;
                                        store_wr.cell_color = text_color_reg;
                                        if (c1 > CMP_W'(head_hi_reg))
                                        begin
                                            head_hi_next = HI_W'(c1);
                                            fin_hi       = HI_W'(c1);
                                        end
                                        if (c1 >= CMP_W'(COLUMNS))
                                        begin
                                            advance = 1'b1;
                                        end
                                        else
                                        begin
                                            cursor_next = c1[COL_W-1:0];
                                        end
                                    end
                                    blink_phase_next = 1'b1;
                                    blink_count_next = '0;
                                end
                            end

                            // line advance: seal the live line's marker, open the next
                            if (advance)
                            begin
                                store_wr.info_we   = 1'b1;
                                store_wr.info_row  = head_row_reg;
                                store_wr.info_hi   = fin_hi;
                                store_wr.info_fill = head_fill_reg;
                                head_lines_next    = head_lines_reg + 32'd1;
                                head_row_next      = (head_row_reg == LINE_W'(LINES - 1))
                                                     ? '0 : head_row_reg + LINE_W'(1);
                                cursor_next        = '0;
                                head_hi_next       = '0;
                                head_fill_next     = text_color_reg;
                            end
                        end
                        FUNC_SET_COLOR:
                        begin
                            text_color_next = req_reg.new_color;
                        end
                        FUNC_TICK:
                        begin
                            if (enable_reg)
                            begin
                                if (cnt >= divider_reg)
                                begin
                                    blink_count_next = '0;
                                    blink_phase_next = !blink_phase_reg;
                                end
                                else
                                begin
                                    blink_count_next = cnt;
                                end
                            end
                        end
                        FUNC_SCROLL:
                        begin
                            if (enable_reg)
                            begin
                                v = $signed({2'b00, view_back_reg})
                                    + 34'($signed(req_reg.scroll_lines));
                                if (v[33])
                                begin
                                    view_back_next = '0;
                                end
                                else if (v > $signed({2'b00, head_lines_reg}))
                                begin
                                    view_back_next = head_lines_reg;
                                end
                                else
                                begin
                                    view_back_next = v[31:0];
                                end
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (enable_reg)
                            begin
                                head_lines_next    = '0;
                                head_row_next      = '0;
                                cursor_next        = '0;
                                view_back_next     = '0;
                                head_hi_next       = '0;
                                head_fill_next     = clear_color_reg;
                                base_color_next    = clear_color_reg;
                                store_wr.clear_all = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    out_valid_next                  = 1'b1;
                    out_data_next.cursor_column     = cursor_next;
                    out_data_next.head_count        = head_lines_next;
                    out_data_next.scrollback_offset = view_back_next;
                    out_data_next.cursor_shown      = blink_phase_next;
                    out_data_next.escape_active     = escape_next;
                    if (req_reg.func == FUNC_READ_CELL && in_range)
                    begin
                        out_data_next.cell_char  = store_rsp.cell_char;
                        out_data_next.cell_color = store_rsp.cell_color;
                    end
                    else
                    begin
                        out_data_next.cell_char  = '0;
                        out_data_next.cell_color = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            req_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            enable_reg      <= 1'b1;
            divider_reg     <= DIVIDER_RESET;
            clear_color_reg <= CLEAR_COLOR_RESET;
            cursor_reg      <= '0;
            head_lines_reg  <= '0;
            head_row_reg    <= '0;
            head_hi_reg     <= '0;
            head_fill_reg   <= CLEAR_COLOR_RESET;
            base_color_reg  <= CLEAR_COLOR_RESET;
            view_back_reg   <= '0;
            text_color_reg  <= CLEAR_COLOR_RESET;
            escape_reg      <= 1'b0;
            blink_count_reg <= '0;
            blink_phase_reg <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            enable_reg      <= enable_next;
            divider_reg     <= divider_next;
            clear_color_reg <= clear_color_next;
            cursor_reg      <= cursor_next;
            head_lines_reg  <= head_lines_next;
            head_row_reg    <= head_row_next;
            head_hi_reg     <= head_hi_next;
            head_fill_reg   <= head_fill_next;
            base_color_reg  <= base_color_next;
            view_back_reg   <= view_back_next;
            text_color_reg  <= text_color_next;
            escape_reg      <= escape_next;
            blink_count_reg <= blink_count_next;
            blink_phase_reg <= blink_phase_next;
        end
    end

    // Scrollback never reaches past the oldest counted line
    a_view_within_head: assert property (@(posedge clk) disable iff (!rst_n)
        view_back_reg <= head_lines_reg)
        else $error("scrollback offset above head count");

    // Cursor stays on the live line and never past the end of its written prefix
    a_cursor_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cursor_reg) <= CMP_W'(head_hi_reg)
        && CMP_W'(cursor_reg) < CMP_W'(COLUMNS))
        else $error("cursor outside written prefix");

    // A new result only ever comes out of the execute cycle
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("result loaded outside execute");

endmodule
